/* rtl/cdid_pkg.sv */
// cdid_pkg: types, constants and arithmetic helpers for the CD TOC disc-id block.
// Used by the channel interfaces and by every cdid_* module; depends on nothing.
`timescale 1ns / 1ps

package cdid_pkg;

  // Track limit and field widths
  localparam int unsigned MAX_TRACKS   = 99;
  localparam int unsigned MIN_W        = 7;
  localparam int unsigned SEC_W        = 6;
  localparam int unsigned TOTAL_W      = 13;  // up to 127*60+63 = 7683
  localparam int unsigned DSUM_W       = 6;   // digit sum of a 13-bit value
  localparam int unsigned DTOT_W       = 12;  // running digit total
  localparam int unsigned TRK_W        = 7;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned SPAN_W       = 24;  // span bits that survive the << 8

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH   = 2;
  localparam int unsigned FIFO_AW      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  localparam logic [TRK_W-1:0] MAX_TRACKS_C = TRK_W'(MAX_TRACKS);

  typedef logic [MIN_W-1:0]   minutes_t;
  typedef logic [SEC_W-1:0]   seconds_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [DSUM_W-1:0]  dsum_t;
  typedef logic [DTOT_W-1:0]  dtot_t;
  typedef logic [TRK_W-1:0]   trk_t;
  typedef logic [ID_W-1:0]    disc_id_t;

  // One classified TOC entry, front to back
  typedef struct packed {
    logic   leadout;
    total_t total;
    dsum_t  dsum;
  } entry_t;

  // floor(v / 100) for v < 8192, reciprocal 5243 / 2^19
  function automatic logic [6:0] div100(input total_t v);
    logic [25:0] prod;
    begin
      prod   = 26'(v) * 26'd5243;
      div100 = prod[25:19];
    end
  endfunction

  // floor(x / 10) for x < 128, reciprocal 205 / 2^11
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] prod;
    begin
      prod  = 15'(x) * 15'd205;
      div10 = prod[14:11];
    end
  endfunction

  // Decimal digit sum of a 13-bit value: split at 100, then each half at 10
  function automatic dsum_t digit_sum(input total_t v);
    logic [6:0]  q;
    logic [6:0]  r;
    logic [13:0] q100;
    logic [3:0]  q_hi;
    logic [3:0]  r_hi;
    logic [6:0]  q_lo;
    logic [6:0]  r_lo;
    begin
      q    = div100(v);
      q100 = 14'(q) * 14'd100;
      r    = 7'(14'(v) - q100);
      q_hi = div10(q);
      r_hi = div10(r);
      q_lo = q - (7'(q_hi) * 7'd10);
      r_lo = r - (7'(r_hi) * 7'd10);
      digit_sum = DSUM_W'(q_hi) + DSUM_W'(q_lo[3:0]) + DSUM_W'(r_hi) + DSUM_W'(r_lo[3:0]);
    end
  endfunction

  // v mod 255 for a 12-bit value: fold the high nibble, one correction
  function automatic logic [7:0] mod255(input dtot_t v);
    logic [8:0] s;
    begin
      s = 9'(v[11:8]) + 9'(v[7:0]);
      if (s >= 9'd255) begin
        s = s - 9'd255;
      end
      mod255 = s[7:0];
    end
  endfunction

endpackage

/* rtl/cdid_ifs.sv */
// Valid/ready channel interfaces for TOC entries in and disc ids out.
// Depends on cdid_pkg for the payload types.
`timescale 1ns / 1ps

interface cdid_in_if;
  logic                valid;
  logic                ready;
  cdid_pkg::minutes_t  minutes;
  cdid_pkg::seconds_t  seconds;
  logic                is_leadout;

  modport source (output valid, output minutes, output seconds, output is_leadout,
                  input ready);
  modport sink   (input valid, input minutes, input seconds, input is_leadout,
                  output ready);
endinterface

interface cdid_out_if;
  logic                valid;
  logic                ready;
  cdid_pkg::disc_id_t  disc_id;
  cdid_pkg::trk_t      track_total;
  logic                too_many_tracks;

  modport source (output valid, output disc_id, output track_total,
                  output too_many_tracks, input ready);
  modport sink   (input valid, input disc_id, input track_total,
                  input too_many_tracks, output ready);
endinterface

/* rtl/cdid_front.sv */
// cdid_front: accepts TOC entries, forms total seconds, then the digit sum.
// Depends on cdid_pkg and the cdid_in_if interface.
`timescale 1ns / 1ps

module cdid_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  cdid_in_if.sink           in_i,
  output logic              push_o,
  output cdid_pkg::entry_t  push_entry_o,
  input  logic              push_ready_i
);
  import cdid_pkg::*;

  logic   a_valid_q, a_valid_d;
  logic   a_leadout_q;
  total_t a_total_q;
  total_t total_in;
  logic   in_xfer;
  logic   advance;

  // minutes*60 + seconds as (m<<6) - (m<<2) + s
  assign total_in = (TOTAL_W'(in_i.minutes) << 6) - (TOTAL_W'(in_i.minutes) << 2)
                  + TOTAL_W'(in_i.seconds);

  assign advance   = a_valid_q && push_ready_i;
  assign in_i.ready = !a_valid_q || push_ready_i;
  assign in_xfer   = in_i.valid && in_i.ready;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_xfer) begin
      a_valid_d = 1'b1;
    end else if (advance) begin
      a_valid_d = 1'b0;
    end
  end

  // Stage register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  // Stage register: payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_total_q   <= total_in;
      a_leadout_q <= in_i.is_leadout;
    end
  end

  // Digit sum on the registered total, into the queue
  assign push_o               = a_valid_q;
  assign push_entry_o.leadout = a_leadout_q;
  assign push_entry_o.total   = a_total_q;
  assign push_entry_o.dsum    = digit_sum(a_total_q);

  // A held entry stays held until the queue takes it
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !push_ready_i |=> a_valid_q && $stable(a_total_q))
    else $error("front stage dropped an entry");

  // Never accept while the stage is full and blocked
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !push_ready_i |-> !in_xfer)
    else $error("front stage overwritten");

endmodule

/* rtl/cdid_fifo.sv */
// cdid_fifo: short queue of classified entries between front and back.
// Depends on cdid_pkg.
`timescale 1ns / 1ps

module cdid_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cdid_pkg::entry_t  push_entry_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output cdid_pkg::entry_t  pop_entry_o,
  input  logic              pop_i
);
  import cdid_pkg::*;

  entry_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]     count_q;
  logic                   do_push, do_pop;

  assign push_ready_o = (count_q != FIFO_CW'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count past depth");

  q_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

/* rtl/cdid_back.sv */
// cdid_back: per-disc accumulation and disc-id output register.
// Depends on cdid_pkg and the cdid_out_if interface.
`timescale 1ns / 1ps

module cdid_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  cdid_pkg::entry_t  pop_entry_i,
  output logic              pop_o,
  cdid_out_if.source        out_o
);
  import cdid_pkg::*;

  dtot_t              digit_total_q;
  trk_t               tracks_q;
  total_t             first_q;
  logic               overflow_q;
  logic               out_valid_q, out_valid_d;
  disc_id_t           id_q;
  trk_t               trk_out_q;
  logic               ovf_out_q;
  logic               pop;
  logic               pop_track, pop_lead;
  logic [SPAN_W-1:0]  span;
  disc_id_t           id_d;

  // Track entries never block; a lead-out needs the output register free
  assign pop = pop_valid_i && (!pop_entry_i.leadout || !out_valid_q || out_o.ready);
  assign pop_o     = pop;
  assign pop_track = pop && !pop_entry_i.leadout;
  assign pop_lead  = pop && pop_entry_i.leadout;

  // Span keeps only the bits that survive the shift; wraps when negative
  assign span = (tracks_q != '0) ? SPAN_W'(pop_entry_i.total) - SPAN_W'(first_q) : '0;
  assign id_d = {mod255(digit_total_q), 24'd0} | {span, 8'd0} | ID_W'(tracks_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_lead) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Disc state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_total_q <= '0;
      tracks_q      <= '0;
      first_q       <= '0;
      overflow_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_lead) begin
        digit_total_q <= '0;
        tracks_q      <= '0;
        first_q       <= '0;
        overflow_q    <= 1'b0;
      end else if (pop_track) begin
        if (tracks_q >= MAX_TRACKS_C) begin
          overflow_q <= 1'b1;
        end else begin
          if (tracks_q == '0) begin
            first_q <= pop_entry_i.total;
          end
          digit_total_q <= digit_total_q + DTOT_W'(pop_entry_i.dsum);
          tracks_q      <= tracks_q + 1'b1;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_lead) begin
      id_q      <= id_d;
      trk_out_q <= tracks_q;
      ovf_out_q <= overflow_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.disc_id         = id_q;
  assign out_o.track_total     = trk_out_q;
  assign out_o.too_many_tracks = ovf_out_q;

  b_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_lead |=> tracks_q == '0 && digit_total_q == '0 && !overflow_q)
    else $error("disc state not cleared after lead-out");

  b_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tracks_q <= MAX_TRACKS_C)
    else $error("track count past limit");

  b_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop_lead))
    else $error("result without lead-out");

  b_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !pop_lead)
    else $error("pending result overwritten");

endmodule

/* rtl/cd_toc_disc_id.sv */
// cd_toc_disc_id: top level of the CD table-of-contents disc-id block.
// Depends on cdid_pkg, cdid_ifs, cdid_front, cdid_fifo and cdid_back.
//
// Usage:
//   in_i  carries one TOC entry per transfer: minutes, seconds, is_leadout.
//         Track entries come first, then one lead-out entry closes the disc.
//   out_o carries one result per lead-out: disc_id, track_total and
//         too_many_tracks. Track entries give no result.
//   Throughput: one entry per cycle, sustained, also across lead-outs while
//         out_o keeps taking results.
//   Path: a lead-out transferred on in_i passes the input stage register and
//         the queue (its digit sum is formed combinationally on the way in),
//         then the accumulator loads the output register that drives out_o.
//   Track entries past the 99th are dropped and flag too_many_tracks.
//   Reset clears the disc state, the queue and the output register valid.
//   When out_o stalls, the result waits in the output register; track entries
//   keep flowing, and a following lead-out waits in the two-entry queue, which
//   in turn holds off in_i once full.
`timescale 1ns / 1ps

module cd_toc_disc_id (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdid_in_if.sink     in_i,
  cdid_out_if.source  out_o
);
  import cdid_pkg::*;

  logic   push, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop;
  entry_t pop_entry;

  cdid_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  cdid_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_i        (pop)
  );

  cdid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for cd_toc_disc_id, driving TOC entries and checking disc ids.
// Depends on cdid_pkg, the cdid_in_if / cdid_out_if interfaces and the cd_toc_disc_id RTL.
`timescale 1ns / 1ps

module testbench;
  import cdid_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 10;

  // One TOC entry as offered on the input channel
  typedef struct {
    minutes_t minutes;
    seconds_t seconds;
    logic     leadout;
  } toc_entry_t;

  // One disc-id result as expected on the output channel
  typedef struct {
    disc_id_t disc_id;
    trk_t     track_total;
    logic     too_many_tracks;
  } disc_result_t;

  logic clk_i;
  logic rst_ni;

  cdid_in_if  in_if ();
  cdid_out_if out_if ();

  cd_toc_disc_id u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  toc_entry_t   toc_q[$];
  disc_result_t disc_results_q[$];

  // Shadow of the per-disc accumulators
  dtot_t  acc_digits;
  trk_t   acc_tracks;
  total_t acc_first;
  logic   acc_overflow;

  logic        in_xfer;
  logic        out_xfer;
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned results_seen;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic int unsigned decimal_digits(input int unsigned v);
    int unsigned s;
    s = 0;
    while (v > 0) begin
      s = s + v % 10;
      v = v / 10;
    end
    return s;
  endfunction

  // Fold one accepted entry into the shadow state; a lead-out yields a disc id
  task automatic disc_id_predict(input minutes_t mins, input seconds_t secs, input logic lo);
    int unsigned  secs_total;
    logic [31:0]  span;
    disc_result_t res;
    secs_total = int'(mins) * 60 + int'(secs);
    if (!lo) begin
      if (acc_tracks >= trk_t'(MAX_TRACKS)) begin
        acc_overflow = 1'b1;
      end else begin
        if (acc_tracks == '0) begin
          acc_first = total_t'(secs_total);
        end
        acc_digits = dtot_t'(int'(acc_digits) + decimal_digits(secs_total));
        acc_tracks = acc_tracks + 1'b1;
      end
    end else begin
      span = '0;
      if (acc_tracks != '0) begin
        span = 32'(secs_total) - 32'(acc_first);
      end
      res.disc_id         = (32'(int'(acc_digits) % 255) << 24) | (span << 8) | 32'(acc_tracks);
      res.track_total     = acc_tracks;
      res.too_many_tracks = acc_overflow;
      disc_results_q.push_back(res);
      acc_digits   = '0;
      acc_tracks   = '0;
      acc_first    = '0;
      acc_overflow = 1'b0;
    end
  endtask

  task automatic push_entry(input int unsigned mins, input int unsigned secs, input logic lo);
    toc_entry_t e;
    e.minutes = minutes_t'(mins);
    e.seconds = seconds_t'(secs);
    e.leadout = lo;
    toc_q.push_back(e);
  endtask

  // Input side: record transfers and predict at the rising edge
  always @(posedge clk_i) begin
    in_xfer <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      disc_id_predict(in_if.minutes, in_if.seconds, in_if.is_leadout);
    end
  end

  // Driver: next entry after a transfer or an idle gap
  int unsigned src_wait;
  logic        src_calm;
  toc_entry_t  src_cur;

  always @(negedge clk_i) begin
    if (rst_ni && !(in_if.valid && !in_xfer)) begin
      if (src_wait > 0) begin
        in_if.valid <= 1'b0;
        src_wait = src_wait - 1;
      end else if (toc_q.size() != 0) begin
        src_cur = toc_q.pop_front();
        in_if.minutes    <= src_cur.minutes;
        in_if.seconds    <= src_cur.seconds;
        in_if.is_leadout <= src_cur.leadout;
        in_if.valid      <= 1'b1;
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        src_wait = src_calm ? 0 : $urandom_range(0, 7);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each transfer, one long hold-off early on
  int unsigned sink_wait;
  logic        sink_calm;
  logic        hold_done;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_xfer) begin
        if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
        sink_wait = sink_calm ? 0 : $urandom_range(0, 7);
        if (results_seen == 3 && !hold_done) begin
          sink_wait = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (sink_wait > 0) begin
        out_if.ready <= 1'b0;
        sink_wait = sink_wait - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expected disc id
  disc_result_t mon_exp;

  always @(posedge clk_i) begin
    out_xfer <= rst_ni && out_if.valid && out_if.ready;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen <= results_seen + 1;
      if (disc_results_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < MAX_REPORTS) begin
          $display("unexpected result: disc_id=%h tracks=%0d flag=%b",
                   out_if.disc_id, out_if.track_total, out_if.too_many_tracks);
        end
      end else begin
        mon_exp = disc_results_q.pop_front();
        if (out_if.disc_id !== mon_exp.disc_id ||
            out_if.track_total !== mon_exp.track_total ||
            out_if.too_many_tracks !== mon_exp.too_many_tracks) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < MAX_REPORTS) begin
            $display("mismatch: exp disc_id=%h tracks=%0d flag=%b, got disc_id=%h tracks=%0d flag=%b",
                     mon_exp.disc_id, mon_exp.track_total, mon_exp.too_many_tracks,
                     out_if.disc_id, out_if.track_total, out_if.too_many_tracks);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("testbench failed");
    $finish;
  end

  // Stimulus and end of run
  int unsigned disc_no;
  int unsigned n_trk;
  int unsigned step_max;
  int unsigned t;
  int unsigned k;
  int unsigned kind;

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.minutes    = '0;
    in_if.seconds    = '0;
    in_if.is_leadout = 1'b0;
    out_if.ready     = 1'b0;
    in_xfer          = 1'b0;
    out_xfer         = 1'b0;
    cycle_cnt        = 0;
    mismatch_cnt     = 0;
    results_seen     = 0;
    acc_digits       = '0;
    acc_tracks       = '0;
    acc_first        = '0;
    acc_overflow     = 1'b0;
    src_wait         = 0;
    src_calm         = 1'b0;
    sink_wait        = 0;
    sink_calm        = 1'b0;
    hold_done        = 1'b0;

    // Directed: lead-out with no tracks, at zero and at the field maxima
    push_entry(0, 0, 1'b1);
    push_entry(127, 63, 1'b1);
    // Extreme track times, in-range lead-out
    push_entry(0, 0, 1'b0);
    push_entry(127, 63, 1'b0);
    push_entry(99, 59, 1'b1);
    // Lead-out earlier than the first track: span wraps into the checksum byte
    push_entry(50, 30, 1'b0);
    push_entry(60, 0, 1'b0);
    push_entry(10, 5, 1'b1);
    // Single track, lead-out at the same time: zero span
    push_entry(0, 2, 1'b0);
    push_entry(0, 2, 1'b1);
    // Out-of-range fields: seconds only, minutes only, then both
    push_entry(0, 63, 1'b0);
    push_entry(127, 0, 1'b0);
    push_entry(100, 60, 1'b0);
    push_entry(127, 63, 1'b1);
    // Typical short disc
    push_entry(0, 2, 1'b0);
    push_entry(4, 17, 1'b0);
    push_entry(9, 48, 1'b0);
    push_entry(15, 1, 1'b0);
    push_entry(21, 36, 1'b1);

    // Random discs: mostly ordered track times, some noise and broken discs;
    // the first disc runs past the track limit
    disc_no = 0;
    while (toc_q.size() < 620) begin
      kind = $urandom_range(0, 19);
      if (disc_no == 0 || kind == 0) n_trk = $urandom_range(100, 105);
      else if (kind == 1) n_trk = 0;
      else n_trk = $urandom_range(1, 10);
      step_max = (n_trk > 20) ? 55 : 600;
      t = $urandom_range(0, 300);
      for (k = 0; k < n_trk; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_entry($urandom_range(0, 127), $urandom_range(0, 63), 1'b0);
        end else begin
          push_entry(t / 60, t % 60, 1'b0);
        end
        t = t + $urandom_range(1, step_max);
        if (t > 5999) t = 5999;
      end
      if ($urandom_range(0, 9) == 0) begin
        push_entry($urandom_range(0, 127), $urandom_range(0, 63), 1'b1);
      end else begin
        push_entry(t / 60, t % 60, 1'b1);
      end
      disc_no++;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (toc_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (disc_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && disc_results_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
